// ===== rtl/core/uart_ri_pkg.sv =====
// Shared codes and result layout for the UART register interface.
package uart_ri_pkg;

  // Request kinds carried on the slave tuser
  localparam logic [2:0] ACT_BUS_READ  = 3'd0;
  localparam logic [2:0] ACT_BUS_WRITE = 3'd1;
  localparam logic [2:0] ACT_LINE_BYTE = 3'd2;
  localparam logic [2:0] ACT_RX_TIMER  = 3'd3;
  localparam logic [2:0] ACT_TX_TIMER  = 3'd4;

  // Register offsets
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_RSVD = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  // Interrupt identification codes
  localparam logic [7:0] IIR_RX_DATA = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE    = 8'h01;

  localparam logic [7:0] LSR_TX_IDLE = 8'h60;
  localparam int unsigned DLAB_BIT = 7;

  // Result of one request, highest field first
  typedef struct packed {
    logic       rx_dropped;
    logic       tx_timer_start;
    logic       rx_timer_start;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       irq_pulse;
    logic [7:0] read_value;
  } result_t;

endpackage

// ===== rtl/core/uart_ri_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uart_ri_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first: a read at the address being written returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/uart_register_interrupt_model.sv =====
// Register file of a PC-style serial UART with receive queue and interrupt pulses.
// One request is taken per clock cycle when the result register is free or being
// drained, and its result is registered and appears on the master side in the cycle after acceptance.
// A request is a bus read or write of one of the eight byte registers, a byte arriving
// from the line, or a receive or transmit timer expiry; exactly one result comes back
// for each. The receive queue sits in a RAM whose read port always prefetches the
// entry at the queue head, with a bypass for a byte written to that entry in the
// previous cycle, so data reads pop at full rate. Bytes arriving with the queue full
// are dropped and flagged.
module uart_register_interrupt_model #(
  parameter int RX_QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_address[2:0], write_value[10:3], line_byte[18:11], zero [23:19]
  input  logic [23:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value[7:0], irq_pulse[8], tx_valid[9], tx_byte[17:10], rx_timer_start[18],
  // tx_timer_start[19], rx_dropped[20], zero [23:21]
  output logic [23:0] m_axis_tdata
);
  import uart_ri_pkg::*;

  localparam int AW = (RX_QUEUE_DEPTH > 1) ? $clog2(RX_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(RX_QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] QFull = CW'(RX_QUEUE_DEPTH);
  localparam logic [AW-1:0] HeadLast = AW'(RX_QUEUE_DEPTH - 1);
  localparam logic [SW-1:0] DepthS = SW'(RX_QUEUE_DEPTH);

  logic [2:0] in_action;
  logic [2:0] in_addr;
  logic [7:0] in_wval;
  logic [7:0] in_lbyte;
  logic       in_fire;

  assign in_action = s_axis_tuser;
  assign in_addr   = s_axis_tdata[2:0];
  assign in_wval   = s_axis_tdata[10:3];
  assign in_lbyte  = s_axis_tdata[18:11];

  logic [7:0]    lcr_q, lcr_d;
  logic [15:0]   dll_q, dll_d;
  logic [3:0]    ier_q, ier_d;
  logic [4:0]    mcr_q, mcr_d;
  logic [7:0]    scr_q, scr_d;
  logic [7:0]    rx_hold_q, rx_hold_d;
  logic          rx_ready_q, rx_ready_d;
  logic          tx_ready_q, tx_ready_d;
  logic          rx_int_q, rx_int_d;
  logic          tx_int_q, tx_int_d;
  logic [CW-1:0] rx_count_q, rx_count_d;
  logic [AW-1:0] head_q, head_d;
  logic          out_valid_q;
  result_t       out_q, res_d;

  // Queue RAM and head prefetch
  logic          q_we;
  logic [AW-1:0] q_tail;
  logic [7:0]    q_rdata;
  logic          byp_valid_q;
  logic [7:0]    byp_data_q;
  logic [7:0]    q_front;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] head_inc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign tail_sum = SW'(head_q) + SW'(rx_count_q);
  assign q_tail   = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign head_inc = (head_q == HeadLast) ? '0 : head_q + AW'(1);
  assign q_front  = byp_valid_q ? byp_data_q : q_rdata;

  uart_ri_ram #(
    .Width(8),
    .Depth(RX_QUEUE_DEPTH)
  ) u_rx_queue (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_tail),
    .wdata_i(in_lbyte),
    .raddr_i(head_d),
    .rdata_o(q_rdata)
  );

  logic dlab;
  logic rx_en, tx_en, new_rx_en, new_tx_en;

  assign dlab      = lcr_q[DLAB_BIT];
  assign rx_en     = ier_q[0];
  assign tx_en     = ier_q[1];
  assign new_rx_en = in_wval[0];
  assign new_tx_en = in_wval[1];

  always_comb begin
    lcr_d      = lcr_q;
    dll_d      = dll_q;
    ier_d      = ier_q;
    mcr_d      = mcr_q;
    scr_d      = scr_q;
    rx_hold_d  = rx_hold_q;
    rx_ready_d = rx_ready_q;
    tx_ready_d = tx_ready_q;
    rx_int_d   = rx_int_q;
    tx_int_d   = tx_int_q;
    rx_count_d = rx_count_q;
    head_d     = head_q;
    q_we       = 1'b0;
    res_d      = '0;

    if (in_fire) begin
      case (in_action)
        ACT_BUS_READ: begin
          case (in_addr)
            REG_DATA: begin
              if (dlab) begin
                res_d.read_value = dll_q[7:0];
              end else begin
                if (rx_count_q != '0) begin
                  rx_hold_d  = q_front;
                  head_d     = head_inc;
                  rx_count_d = rx_count_q - CW'(1);
                end
                rx_ready_d           = 1'b0;
                rx_int_d             = 1'b0;
                res_d.rx_timer_start = 1'b1;
                res_d.read_value     = rx_hold_d;
              end
            end
            REG_IER: res_d.read_value = dlab ? dll_q[15:8] : {4'b0, ier_q};
            REG_IIR: begin
              if (rx_en && rx_int_q) begin
                res_d.read_value = IIR_RX_DATA;
              end else if (tx_en && tx_int_q) begin
                tx_int_d         = 1'b0;
                res_d.read_value = IIR_TX_EMPTY;
              end else begin
                res_d.read_value = IIR_NONE;
              end
            end
            REG_LCR: res_d.read_value = lcr_q;
            REG_MCR: res_d.read_value = {3'b0, mcr_q};
            REG_LSR: res_d.read_value = (tx_ready_q ? LSR_TX_IDLE : 8'h00) |
                                        {7'b0, rx_ready_q};
            REG_RSVD: res_d.read_value = 8'h00;
            default: res_d.read_value = scr_q;
          endcase
        end
        ACT_BUS_WRITE: begin
          case (in_addr)
            REG_DATA: begin
              if (dlab) begin
                dll_d[7:0] = in_wval;
              end else begin
                res_d.tx_valid       = 1'b1;
                res_d.tx_byte        = in_wval;
                res_d.tx_timer_start = 1'b1;
                tx_ready_d           = 1'b0;
                tx_int_d             = 1'b0;
              end
            end
            REG_IER: begin
              if (dlab) begin
                dll_d[15:8] = in_wval;
              end else begin
                ier_d = in_wval[3:0];
                if (new_rx_en) rx_int_d = rx_ready_q;
                if (new_tx_en) tx_int_d = tx_ready_q;
                // Pulse only on a transition from nothing pending to something pending
                res_d.irq_pulse = (!rx_en || !rx_int_d) && (!tx_en || !tx_int_d) &&
                                  ((new_rx_en && rx_int_d) || (new_tx_en && tx_int_d));
              end
            end
            REG_LCR: lcr_d = in_wval;
            REG_MCR: mcr_d = in_wval[4:0];
            REG_SCR: scr_d = in_wval;
            default: ;
          endcase
        end
        ACT_LINE_BYTE: begin
          if (rx_count_q == QFull) begin
            res_d.rx_dropped = 1'b1;
          end else begin
            q_we       = 1'b1;
            rx_count_d = rx_count_q + CW'(1);
          end
        end
        ACT_RX_TIMER: begin
          if (rx_count_q != '0) begin
            rx_ready_d      = 1'b1;
            rx_int_d        = 1'b1;
            res_d.irq_pulse = rx_en && (!tx_en || !tx_int_q);
          end
        end
        ACT_TX_TIMER: begin
          tx_ready_d      = 1'b1;
          tx_int_d        = 1'b1;
          res_d.irq_pulse = tx_en && (!rx_en || !rx_int_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q       <= '0;
      dll_q       <= '0;
      ier_q       <= '0;
      mcr_q       <= '0;
      scr_q       <= '0;
      rx_hold_q   <= '0;
      rx_ready_q  <= 1'b0;
      tx_ready_q  <= 1'b1;
      rx_int_q    <= 1'b0;
      tx_int_q    <= 1'b0;
      rx_count_q  <= '0;
      head_q      <= '0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lcr_q      <= lcr_d;
      dll_q      <= dll_d;
      ier_q      <= ier_d;
      mcr_q      <= mcr_d;
      scr_q      <= scr_d;
      rx_hold_q  <= rx_hold_d;
      rx_ready_q <= rx_ready_d;
      tx_ready_q <= tx_ready_d;
      rx_int_q   <= rx_int_d;
      tx_int_q   <= tx_int_d;
      rx_count_q <= rx_count_d;
      head_q     <= head_d;
      // Forward a byte written to the entry the RAM is prefetching
      byp_valid_q <= q_we && (q_tail == head_d);
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= in_lbyte;
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_q};

  logic pop_req;
  assign pop_req = in_fire && (in_action == ACT_BUS_READ) && (in_addr == REG_DATA) &&
                   !dlab && (rx_count_q != '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count_q <= QFull)
    else $error("receive queue count beyond depth");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_action == ACT_LINE_BYTE) && (rx_count_q == QFull))
      |=> (out_q.rx_dropped && (rx_count_q == QFull)))
    else $error("full queue did not drop the line byte");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_req |=> (rx_count_q == $past(rx_count_q) - CW'(1)))
    else $error("data read did not pop the queue");

  a_tx_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.tx_valid == out_q.tx_timer_start))
    else $error("transmitted byte without transmit timer request");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the UART register file with receive queue and interrupts.
module tb_top;
  import uart_ri_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RXQ_DEPTH = 16;
  localparam int TOTAL_REQUESTS = 1550;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PERCENT = 14;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  // Register shadow: mirrors the block state and queues the result due for each request
  class uart_reg_shadow;
    logic [7:0]  lcr;
    logic [15:0] divisor;
    logic [3:0]  ier;
    logic [4:0]  mcr;
    logic [7:0]  scr;
    logic [7:0]  rx_hold;
    bit          rx_ready;
    bit          tx_ready;
    bit          rx_flag;
    bit          tx_flag;
    logic [7:0]  rxq[RXQ_DEPTH];
    int          rx_count;
    int          rx_head;
    result_t     due_results[$];
    int          errors;

    function new();
      lcr = '0;
      divisor = '0;
      ier = '0;
      mcr = '0;
      scr = '0;
      rx_hold = '0;
      rx_ready = 1'b0;
      tx_ready = 1'b1;
      rx_flag = 1'b0;
      tx_flag = 1'b0;
      rx_count = 0;
      rx_head = 0;
      errors = 0;
    endfunction

    function void note_request(logic [2:0] act, logic [2:0] addr, logic [7:0] wv,
                               logic [7:0] lb);
      result_t r;
      bit dlab;
      bit old_rx;
      bit old_tx;
      r = '0;
      dlab = lcr[DLAB_BIT];
      case (act)
        ACT_BUS_READ: begin
          case (addr)
            REG_DATA: begin
              if (dlab) begin
                r.read_value = divisor[7:0];
              end else begin
                // an empty queue returns the last byte again
                if (rx_count > 0) begin
                  rx_hold = rxq[rx_head];
                  rx_head = (rx_head + 1) % RXQ_DEPTH;
                  rx_count--;
                end
                rx_ready = 1'b0;
                rx_flag = 1'b0;
                r.rx_timer_start = 1'b1;
                r.read_value = rx_hold;
              end
            end
            REG_IER: r.read_value = dlab ? divisor[15:8] : {4'b0, ier};
            REG_IIR: begin
              if (ier[0] && rx_flag) begin
                r.read_value = IIR_RX_DATA;
              end else if (ier[1] && tx_flag) begin
                tx_flag = 1'b0;
                r.read_value = IIR_TX_EMPTY;
              end else begin
                r.read_value = IIR_NONE;
              end
            end
            REG_LCR: r.read_value = lcr;
            REG_MCR: r.read_value = {3'b0, mcr};
            REG_LSR: r.read_value = (tx_ready ? LSR_TX_IDLE : 8'h00) | {7'b0, rx_ready};
            REG_RSVD: r.read_value = 8'h00;
            default: r.read_value = scr;
          endcase
        end
        ACT_BUS_WRITE: begin
          case (addr)
            REG_DATA: begin
              if (dlab) begin
                divisor[7:0] = wv;
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte = wv;
                r.tx_timer_start = 1'b1;
                tx_ready = 1'b0;
                tx_flag = 1'b0;
              end
            end
            REG_IER: begin
              if (dlab) begin
                divisor[15:8] = wv;
              end else begin
                old_rx = ier[0];
                old_tx = ier[1];
                ier = wv[3:0];
                if (ier[0]) rx_flag = rx_ready;
                if (ier[1]) tx_flag = tx_ready;
                // pulse only when nothing was pending under the old enables
                if ((!old_rx || !rx_flag) && (!old_tx || !tx_flag) &&
                    ((ier[0] && rx_flag) || (ier[1] && tx_flag)))
                  r.irq_pulse = 1'b1;
              end
            end
            REG_LCR: lcr = wv;
            REG_MCR: mcr = wv[4:0];
            REG_SCR: scr = wv;
            default: ;
          endcase
        end
        ACT_LINE_BYTE: begin
          if (rx_count >= RXQ_DEPTH) begin
            r.rx_dropped = 1'b1;
          end else begin
            rxq[(rx_head + rx_count) % RXQ_DEPTH] = lb;
            rx_count++;
          end
        end
        ACT_RX_TIMER: begin
          if (rx_count > 0) begin
            rx_ready = 1'b1;
            rx_flag = 1'b1;
            if (ier[0] && (!ier[1] || !tx_flag)) r.irq_pulse = 1'b1;
          end
        end
        ACT_TX_TIMER: begin
          tx_ready = 1'b1;
          tx_flag = 1'b1;
          if (ier[1] && (!ier[0] || !rx_flag)) r.irq_pulse = 1'b1;
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] d);
      result_t e;
      result_t a;
      if (due_results.size() == 0) begin
        $error("unexpected result %06h with no request outstanding", d);
        errors++;
        return;
      end
      e = due_results.pop_front();
      a = result_t'(d[20:0]);
      compare_field("read_value", 32'(e.read_value), 32'(a.read_value));
      compare_field("irq_pulse", 32'(e.irq_pulse), 32'(a.irq_pulse));
      compare_field("tx_valid", 32'(e.tx_valid), 32'(a.tx_valid));
      compare_field("tx_byte", 32'(e.tx_byte), 32'(a.tx_byte));
      compare_field("rx_timer_start", 32'(e.rx_timer_start), 32'(a.rx_timer_start));
      compare_field("tx_timer_start", 32'(e.tx_timer_start), 32'(a.tx_timer_start));
      compare_field("rx_dropped", 32'(e.rx_dropped), 32'(a.rx_dropped));
      compare_field("padding", 0, 32'(d[23:21]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  uart_reg_shadow shadow = new();
  int  sent_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  uart_register_interrupt_model #(
    .RX_QUEUE_DEPTH(RXQ_DEPTH)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Result side: stall at random except during the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) shadow.check_result(m_axis_tdata);
  end

  // Drive one request from a falling edge, hold until accepted
  task automatic send_request(logic [2:0] act, logic [2:0] addr, logic [7:0] wv,
                              logic [7:0] lb);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, lb, wv, addr};
    s_axis_tuser <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(act, addr, wv, lb);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_read(logic [2:0] addr);
    send_request(ACT_BUS_READ, addr, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_write(logic [2:0] addr, logic [7:0] wv);
    send_request(ACT_BUS_WRITE, addr, wv, 8'($urandom));
  endtask

  // Line control with the divisor latch mostly closed
  function automatic logic [7:0] pick_lcr();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(99) >= 15) v[DLAB_BIT] = 1'b0;
    return v;
  endfunction

  task automatic random_mix(int n);
    int pick;
    logic [2:0] addr;
    logic [7:0] wv;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      addr = 3'($urandom);
      wv = 8'($urandom);
      if (pick < 30) begin
        if ($urandom_range(99) < 40) addr = REG_DATA;
        else if ($urandom_range(99) < 25) addr = REG_IIR;
        send_read(addr);
      end else if (pick < 55) begin
        if (addr == REG_LCR) wv = pick_lcr();
        send_write(addr, wv);
      end else if (pick < 75) begin
        send_request(ACT_LINE_BYTE, addr, wv, 8'($urandom));
      end else if (pick < 85) begin
        send_request(ACT_RX_TIMER, addr, wv, 8'($urandom));
      end else if (pick < 97) begin
        send_request(ACT_TX_TIMER, addr, wv, 8'($urandom));
      end else begin
        send_request(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), addr, wv,
                     8'($urandom));
      end
    end
  endtask

  // Fill the queue, at times past full, then read it back through the data register
  task automatic queue_burst();
    int n;
    int reads;
    send_write(REG_LCR, pick_lcr() & 8'h7F);
    if ($urandom_range(1)) send_write(REG_IER, 8'($urandom));
    n = int'($urandom_range(12, RXQ_DEPTH + 4));
    for (int i = 0; i < n; i++) begin
      send_request(ACT_LINE_BYTE, 3'($urandom), 8'($urandom), 8'($urandom));
    end
    send_request(ACT_RX_TIMER, 3'($urandom), 8'($urandom), 8'($urandom));
    reads = n + 2 - int'($urandom_range(6));
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(99) < 15) send_read(REG_IIR);
      send_read(REG_DATA);
    end
  endtask

  task automatic divisor_access();
    send_write(REG_LCR, 8'h80 | 8'($urandom));
    send_write(REG_DATA, 8'($urandom));
    send_write(REG_IER, 8'($urandom));
    send_read(REG_DATA);
    send_read(REG_IER);
    send_read(REG_LCR);
    send_write(REG_LCR, pick_lcr() & 8'h7F);
  endtask

  initial begin
    bit mid_drained;
    int pick;
    mid_drained = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values, including a data read with the queue empty
    send_read(REG_DATA);
    send_read(REG_IIR);
    send_read(REG_LSR);
    send_read(REG_RSVD);
    // divisor latch through offsets 0 and 1
    send_write(REG_LCR, 8'h80);
    send_write(REG_DATA, 8'hFF);
    send_write(REG_IER, 8'h00);
    send_read(REG_DATA);
    send_read(REG_IER);
    send_write(REG_LCR, 8'h03);
    // enable all: transmit pending already, so a pulse
    send_write(REG_IER, 8'hFF);
    send_read(REG_IIR);
    send_request(ACT_LINE_BYTE, 3'd0, 8'h00, 8'h00);
    send_request(ACT_LINE_BYTE, 3'd7, 8'hFF, 8'hFF);
    send_request(ACT_RX_TIMER, 3'd0, 8'h00, 8'h00);
    send_read(REG_IIR);
    send_read(REG_DATA);
    send_read(REG_DATA);
    send_write(REG_DATA, 8'hA5);
    send_request(ACT_TX_TIMER, 3'd0, 8'h00, 8'h00);
    // writes that are ignored, then a modem control write
    send_write(REG_IIR, 8'hFF);
    send_write(REG_RSVD, 8'hFF);
    send_write(REG_MCR, 8'hFF);
    // receive timer with nothing queued, then an unused action
    send_request(ACT_RX_TIMER, 3'd0, 8'h00, 8'h00);
    send_request(ACT_UNUSED_HI, 3'd7, 8'hFF, 8'hFF);
    wait_drained();

    while (sent_count < TOTAL_REQUESTS) begin
      calm = (sent_count >= 700 && sent_count < 1000);
      if (!mid_drained && sent_count >= 800) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) random_mix($urandom_range(10, 30));
      else if (pick < 80) queue_burst();
      else divisor_access();
    end
    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== uart_register_interrupt_model.f =====
rtl/core/uart_ri_pkg.sv
rtl/core/uart_ri_ram.sv
rtl/core/uart_register_interrupt_model.sv
tb/tb_top.sv
